[hdl/rdc_pkg.sv]
// shared types and constants for the running duplicate counter
package rdc_pkg;

    localparam int HASH_W  = 32;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // one input item
    typedef struct packed {
        logic [HASH_W-1:0] hash_value;
        logic              restart;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [COUNT_W-1:0] collision_count;
        logic               was_seen;
        logic               store_overflow;
    } t_out_item;

    // result offered by the controller to the output register
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_res_chan;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_DONE
    } t_state;

endpackage

[hdl/rdc_ram.sv]
// generic single-write, single-read ram with registered read data
module rdc_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/rdc_ctrl.sv]
// search and update sequencer over the store of distinct values
module rdc_ctrl import rdc_pkg::*; #(
    parameter  int STORE_DEPTH = 256,
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
    localparam int UW = $clog2(STORE_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    input  logic [HASH_W-1:0] i_rd_data,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [HASH_W-1:0] o_wr_data,
    output t_res_chan         o_res,
    input  logic              i_res_take
);

    t_state             r_state, n_state;
    logic [HASH_W-1:0]  r_hash;
    logic [AW-1:0]      r_idx;
    logic [UW-1:0]      r_used;
    logic [COUNT_W-1:0] r_total;
    logic               r_seen;
    t_out_item          r_res;

    logic [UW-1:0]      used_start;
    logic [UW-1:0]      idx_next;
    logic               hit;
    logic               last;
    logic               room;
    logic [COUNT_W-1:0] n_total;

    // scan helpers
    assign used_start = i_in_item.restart ? '0 : r_used;
    assign idx_next   = UW'(r_idx) + UW'(1);
    assign hit        = (i_rd_data == r_hash);
    assign last       = (idx_next == r_used);
    assign room       = (r_used < UW'(STORE_DEPTH));
    assign n_total    = (r_total == COUNT_MAX) ? r_total : r_total + COUNT_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (used_start == '0) ? S_UPDATE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit || last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        o_rd_en    = 1'b0;
        o_rd_addr  = idx_next[AW-1:0];
        o_wr_en    = 1'b0;
        o_res      = '{valid: 1'b0, item: r_res};
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_rd_en    = i_in_valid;
                o_rd_addr  = '0;
            end
            S_SCAN: begin
                o_rd_en = 1'b1;
            end
            S_UPDATE: begin
                o_wr_en = !r_seen && room;
            end
            S_DONE: begin
                o_res.valid = 1'b1;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    assign o_wr_addr = r_used[AW-1:0];
    assign o_wr_data = r_hash;

    // state, fill count and running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_in_valid && i_in_item.restart) begin
                r_used  <= '0;
                r_total <= '0;
            end
            if (r_state == S_UPDATE) begin
                if (r_seen) begin
                    r_total <= n_total;
                end else if (room) begin
                    r_used <= r_used + UW'(1);
                end
            end
        end
    end

    // item payload, scan index and result
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_hash <= i_in_item.hash_value;
                    r_idx  <= '0;
                    r_seen <= 1'b0;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    r_seen <= 1'b1;
                end else begin
                    r_idx <= r_idx + AW'(1);
                end
            end
            S_UPDATE: begin
                r_res.was_seen        <= r_seen;
                r_res.store_overflow  <= !r_seen && !room;
                r_res.collision_count <= r_seen ? n_total : r_total;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

[hdl/running_duplicate_counter.sv]
// Running duplicate counter: for each 32-bit hash value it returns how many
// values of the current set so far repeated an earlier one (saturating at
// 65535), whether this value did, and whether a new value found the store
// full. Distinct values live in a STORE_DEPTH x 32 ram searched one entry
// per cycle through its single read port; a search stops early on a match,
// and a restart item or an empty set skips it. The result sits in an output
// register, so the next item is taken while it waits. The store needs no
// clearing after reset: only written entries are searched.
module running_duplicate_counter import rdc_pkg::*; #(
    parameter int STORE_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [HASH_W-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [HASH_W-1:0] wr_data;
    t_res_chan         res;
    logic              res_take;

    logic              r_out_valid;
    t_out_item         r_out_item;

    // store of distinct values
    rdc_ram #(
        .WIDTH (HASH_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // search and update sequencer
    rdc_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_res      (res),
        .i_res_take (res_take)
    );

    // output register
    assign res_take = res.valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_item <= res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    // a result not yet moved to the output register stays put
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid && !res_take |=> res.valid && $stable(res.item))
        else $error("pending result changed before it was taken");

    // no item is taken while a result is still inside the sequencer
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> !res.valid)
        else $error("item accepted while a result was pending");

    // a value is either a repeat or a new one, never both
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.was_seen && o_out_item.store_overflow))
        else $error("was_seen and store_overflow both set");

    // the store is written only when no lookup is being read
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !rd_en)
        else $error("store written during a search");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// self-checking bench for the running duplicate counter: sets, repeats, store overflow
module tb_top;
    import rdc_pkg::*;

    localparam int STORE_DEPTH = 256;
    localparam int RANDOM_ITEMS = 850;
    localparam int MAX_REPORTS = 40;

    // receiver stall behaviour, changed every so often
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // shadow of the distinct-value store and the running count
    class duplicate_book;
        logic [HASH_W-1:0]  distinct_vals [STORE_DEPTH];
        int unsigned        stored_count;
        logic [COUNT_W-1:0] dup_total;
        t_out_item          expected_counts [$];
        int unsigned        error_count;

        function new();
            stored_count = 0;
            dup_total    = '0;
            error_count  = 0;
        endfunction

        function void flag(string msg);
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("%0t: %s", $time, msg);
            end
        endfunction

        // work out the result for an accepted item
        function void note_hash(t_in_item it);
            t_out_item res;
            logic      hit;
            int        k;
            hit = 1'b0;
            if (it.restart) begin
                stored_count = 0;
                dup_total    = '0;
            end
            for (k = 0; k < stored_count; k++) begin
                if (distinct_vals[k] == it.hash_value) begin
                    hit = 1'b1;
                end
            end
            res.store_overflow = 1'b0;
            if (hit) begin
                if (dup_total != COUNT_MAX) begin
                    dup_total++;
                end
            end else if (stored_count < STORE_DEPTH) begin
                distinct_vals[stored_count] = it.hash_value;
                stored_count++;
            end else begin
                res.store_overflow = 1'b1;
            end
            res.was_seen        = hit;
            res.collision_count = dup_total;
            expected_counts.insert(expected_counts.size(), res);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                flag($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
            end
        endfunction

        // compare a result with the oldest expectation
        function void check_count(t_out_item got);
            t_out_item want;
            if (expected_counts.size() == 0) begin
                flag($sformatf("unexpected result: expected none, got count %0d seen %0b ovf %0b",
                               got.collision_count, got.was_seen, got.store_overflow));
                return;
            end
            want = expected_counts.pop_front();
            if ($isunknown(got)) begin
                flag($sformatf("unknown bits: expected %h, got %h", want, got));
                return;
            end
            compare_field("collision_count", want.collision_count, got.collision_count);
            compare_field("was_seen", want.was_seen, got.was_seen);
            compare_field("store_overflow", want.store_overflow, got.store_overflow);
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    duplicate_book book = new();

    int unsigned       burst_left = 0;
    int unsigned       random_sent = 0;
    logic [HASH_W-1:0] set_history [$];

    running_duplicate_counter #(
        .STORE_DEPTH(STORE_DEPTH)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    // clock
    initial begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #50_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // receiver stall pattern
    t_stall_mode stall_mode = STALL_NONE;
    int unsigned mode_left = 0;
    int unsigned cycle_no = 0;

    always @(posedge clk) begin
        cycle_no++;
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 300);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            default:        out_stall <= ((cycle_no % 11) < 5);
        endcase
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            book.check_count(out_item);
        end
    end

    // offer one item, with bursts and gaps on the sending side
    task automatic send_item(input t_in_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(5, 40);
            end else begin
                gap = $urandom_range(0, 4);
            end
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        book.note_hash(it);
        burst_left--;
    endtask

    // send a value and keep track of the values of the current set
    task automatic send_hash(input logic [HASH_W-1:0] value, input logic restart);
        t_in_item it;
        it.hash_value = value;
        it.restart    = restart;
        if (restart) begin
            set_history.delete();
        end
        set_history.insert(set_history.size(), value);
        send_item(it);
        random_sent++;
    endtask

    function automatic logic [HASH_W-1:0] fresh_hash();
        case ($urandom_range(0, 3))
            0:       return HASH_W'($urandom_range(0, 31));
            1:       return ~HASH_W'($urandom_range(0, 31));
            default: return HASH_W'($urandom());
        endcase
    endfunction

    function automatic logic [HASH_W-1:0] earlier_hash();
        return set_history[$urandom_range(0, set_history.size() - 1)];
    endfunction

    // repeats or fresh values within the current set, mixed by repeat_pct
    task automatic send_mixed(input int unsigned repeat_pct);
        if (set_history.size() != 0 && $urandom_range(0, 99) < repeat_pct) begin
            send_hash(earlier_hash(), 1'b0);
        end else begin
            send_hash(fresh_hash(), 1'b0);
        end
    endtask

    // main sequence
    initial begin
        int unsigned set_len;
        int unsigned n;
        bit          fill_done;

        fill_done = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, repeats, restarts
        send_hash(32'h0000_0000, 1'b1);
        send_hash(32'h0000_0000, 1'b0);
        send_hash(32'hFFFF_FFFF, 1'b0);
        send_hash(32'hFFFF_FFFF, 1'b0);
        send_hash(32'hAAAA_AAAA, 1'b0);
        send_hash(32'h5555_5555, 1'b0);
        send_hash(32'h0000_0000, 1'b0);
        send_hash(32'h5555_5555, 1'b0);
        send_hash(32'hFFFF_FFFF, 1'b1);
        send_hash(32'h0000_0000, 1'b0);
        send_hash(32'hFFFF_FFFF, 1'b0);
        send_hash(32'h0000_0000, 1'b1);
        send_hash(32'h0000_0000, 1'b1);
        send_hash(32'h8000_0000, 1'b0);
        send_hash(32'h0000_0001, 1'b0);
        send_hash(32'h8000_0000, 1'b0);
        send_hash(32'h0000_0001, 1'b0);
        send_hash(32'h7FFF_FFFF, 1'b0);
        send_hash(32'hFFFF_FFFE, 1'b0);
        send_hash(32'h0000_0000, 1'b0);
        random_sent = 0;

        // random: mostly well-formed sets, some noise, one set that overflows the store
        while (random_sent < RANDOM_ITEMS) begin
            n = $urandom_range(0, 19);
            if (!fill_done && random_sent >= 150) begin
                // fill the store, then overflow it and revisit values stored or not
                fill_done = 1'b1;
                send_hash(HASH_W'($urandom()), 1'b1);
                while (book.stored_count < STORE_DEPTH) begin
                    send_mixed(10);
                end
                repeat (30) send_mixed(50);
            end else if (n < 3) begin
                // noise: restarts anywhere, set carries on otherwise
                repeat ($urandom_range(1, 6)) send_hash(fresh_hash(), 1'($urandom_range(0, 1)));
            end else begin
                set_len = (n < 5) ? $urandom_range(40, 100) : $urandom_range(1, 40);
                send_hash(fresh_hash(), 1'b1);
                repeat (set_len - 1) send_mixed(40);
            end
        end

        // drain
        in_valid <= 1'b0;
        while (book.expected_counts.size() != 0) @(posedge clk);
        repeat (STORE_DEPTH + 40) @(posedge clk);

        if (book.error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
